// ===== rtl/tfc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types, tables and bit permutation helpers for the toy Feistel cipher.
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam int ROUNDS = 4;

  typedef logic [3:0] nib_t;
  typedef logic [7:0] byte_t;

  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } kind_t;

  typedef struct packed {
    nib_t l;
    nib_t r;
  } halves_t;

  // Permutation tables: source bit positions, 1 = MSB of the source word.
  localparam logic [3:0] TAB_IP [8] = '{4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
  localparam logic [3:0] TAB_FP [8] = '{4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};
  localparam logic [2:0] TAB_EX [8] = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4, 3'd1};
  localparam logic [2:0] TAB_P4 [4] = '{3'd2, 3'd4, 3'd3, 3'd1};

  localparam nib_t SBOX [16] = '{
    4'd14, 4'd4,  4'd13, 4'd1,
    4'd2,  4'd15, 4'd11, 4'd8,
    4'd3,  4'd10, 4'd6,  4'd5,
    4'd12, 4'd9,  4'd0,  4'd7
  };

  // Initial permutation.
  function automatic byte_t perm_ip(input byte_t src);
    byte_t res;
    for (int i = 0; i < 8; i++) begin
      res[7 - i] = src[3'(8 - int'(TAB_IP[i]))];
    end
    return res;
  endfunction

  // Final permutation, inverse of the initial one.
  function automatic byte_t perm_fp(input byte_t src);
    byte_t res;
    for (int i = 0; i < 8; i++) begin
      res[7 - i] = src[3'(8 - int'(TAB_FP[i]))];
    end
    return res;
  endfunction

  // Expand a half to 8 bits.
  function automatic byte_t expand(input nib_t src);
    byte_t res;
    for (int i = 0; i < 8; i++) begin
      res[7 - i] = src[2'(4 - int'(TAB_EX[i]))];
    end
    return res;
  endfunction

  function automatic nib_t perm_p4(input nib_t src);
    nib_t res;
    for (int i = 0; i < 4; i++) begin
      res[3 - i] = src[2'(4 - int'(TAB_P4[i]))];
    end
    return res;
  endfunction

  // Round function: expand, mix key, S-box on low nibble, permute.
  function automatic nib_t round_fn(input nib_t half, input byte_t key);
    byte_t x;
    x = expand(half) ^ key;
    return perm_p4(SBOX[x[3:0]]);
  endfunction

endpackage

// ===== rtl/toy_feistel_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// toy_feistel_block_cipher_core
// 8-bit DES-like Feistel cipher: initial permutation, four rounds with one
// shared key, final permutation. Encrypt or decrypt per beat.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   ------------------------
//   request   req_valid / req_ready   kind, block_in
//   response  rsp_valid / rsp_ready   block_out
//   key       cipher_key_we           cipher_key
//
// Flow: a request beat lands in the input register, the rounds run in one
// pass of logic, and the result lands in the output register; one beat is
// accepted per cycle when the response side keeps up.
// Reset clears both stage valids and the key; payload registers are not reset.
// Stalls: a held response blocks the input stage only when both stages are
// full; otherwise a new beat is taken while the response waits.
// ----------------------------------------------------------------------------
module toy_feistel_block_cipher_core (
  input  logic       clk,
  input  logic       rst,
  // key register
  input  logic       cipher_key_we,
  input  logic [7:0] cipher_key,
  // request
  input  logic       req_valid,
  output logic       req_ready,
  input  logic       kind,
  input  logic [7:0] block_in,
  // response
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic [7:0] block_out
);

  tfc_pkg::byte_t key;

  // Input stage
  logic           s1_valid;
  tfc_pkg::kind_t s1_kind;
  tfc_pkg::byte_t s1_block;

  // Output stage load and input stage advance
  logic s2_load;
  logic s1_load;

  tfc_pkg::halves_t chain [tfc_pkg::ROUNDS + 1];
  tfc_pkg::byte_t   result;

  // Key register: the rounds read it directly, so write it only while no
  // beat is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cipher_key_we) begin
      key <= cipher_key;
    end
  end

  // Output stage can take a beat when empty or being drained.
  assign s2_load   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || !rsp_valid || rsp_ready;
  assign s1_load   = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind  <= tfc_pkg::kind_t'(kind);
      s1_block <= block_in;
    end
  end

  // Split after the initial permutation, left half high.
  assign chain[0] = tfc_pkg::halves_t'(tfc_pkg::perm_ip(s1_block));

  for (genvar g = 0; g < tfc_pkg::ROUNDS; g++) begin : g_round
    tfc_round u_round (
      .d    (chain[g]),
      .kind (s1_kind),
      .key  (key),
      .q    (chain[g + 1])
    );
  end

  // Join with no final swap, then the inverse permutation.
  assign result = tfc_pkg::perm_fp(tfc_pkg::byte_t'(chain[tfc_pkg::ROUNDS]));

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      block_out <= result;
    end
  end

  // Both stages come up empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !s1_valid && !rsp_valid)
    else $error("stage valid set after reset");

  // An accepted request beat always occupies the input stage next cycle.
  a_req_lands: assert property (@(posedge clk) disable iff (rst)
    s1_load |=> s1_valid)
    else $error("accepted beat lost at input stage");

  // A beat moved forward always shows up as a response.
  a_s2_lands: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> rsp_valid)
    else $error("beat lost between stages");

  // A full input stage that cannot advance keeps its beat.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |=> s1_valid && $stable(s1_block) && $stable(s1_kind))
    else $error("stalled input stage changed");

endmodule

// ===== rtl/tfc_round.sv =====
// ----------------------------------------------------------------------------
// tfc_round
// One Feistel round, either direction.
// ----------------------------------------------------------------------------
module tfc_round (
  input  tfc_pkg::halves_t d,
  input  tfc_pkg::kind_t   kind,
  input  tfc_pkg::byte_t   key,
  output tfc_pkg::halves_t q
);

  always_comb begin
    unique case (kind)
      tfc_pkg::KIND_DEC: begin
        q.l = d.r ^ tfc_pkg::round_fn(d.l, key);
        q.r = d.l;
      end
      tfc_pkg::KIND_ENC: begin
        q.l = d.r;
        q.r = d.l ^ tfc_pkg::round_fn(d.r, key);
      end
      default: begin
        q = d;
      end
    endcase
  end

endmodule
